>>> design/otlm_pkg.sv
package otlm_pkg;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ST_FOUND   = 2'd0,
        ST_INVALID = 2'd1,
        ST_NONE    = 2'd2
    } status_t;

    // What the front decided about one item
    typedef enum logic [1:0] {
        CLS_BREAK   = 2'd0,
        CLS_INVALID = 2'd1,
        CLS_SPECIAL = 2'd2
    } class_t;

    typedef enum logic [5:0] {
        TK_NONE = 6'd0,
        TK_PLUS, TK_MINUS, TK_STAR, TK_SLASH, TK_PERCENT,
        TK_INC, TK_DEC, TK_SHL, TK_SHR, TK_AMP,
        TK_PIPE, TK_CARET, TK_TILDE, TK_GT, TK_GE,
        TK_LT, TK_LE, TK_LAND, TK_LOR, TK_BANG,
        TK_EQ, TK_NE, TK_ASSIGN, TK_ADD_ASN, TK_SUB_ASN,
        TK_MUL_ASN, TK_DIV_ASN, TK_MOD_ASN, TK_OR_ASN, TK_AND_ASN,
        TK_XOR_ASN, TK_SHL_ASN, TK_SHR_ASN, TK_DOT, TK_COMMA,
        TK_COLON, TK_SEMI, TK_QUEST, TK_SQUOTE, TK_DQUOTE,
        TK_LBRACE, TK_RBRACE, TK_LBRACK, TK_RBRACK, TK_LPAREN,
        TK_RPAREN
    } tok_t;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    typedef struct packed {
        class_t     cls;
        tok_t       single;
        logic [7:0] ch;
    } item_t;

    function automatic logic is_special(input logic [7:0] c);
        logic res;
        res = (c >= 8'h21) && (c <= 8'h7E);
        if (c >= 8'h30 && c <= 8'h39) res = 1'b0;
        if (c >= 8'h41 && c <= 8'h5A) res = 1'b0;
        if (c >= 8'h61 && c <= 8'h7A) res = 1'b0;
        if (c == 8'h5F) res = 1'b0;
        return res;
    endfunction

    // One-character token for a byte, TK_NONE if the byte starts no token
    function automatic tok_t single_code(input logic [7:0] c);
        tok_t t;
        case (c)
            8'h2B:   t = TK_PLUS;
            8'h2D:   t = TK_MINUS;
            8'h2A:   t = TK_STAR;
            8'h2F:   t = TK_SLASH;
            8'h25:   t = TK_PERCENT;
            8'h26:   t = TK_AMP;
            8'h7C:   t = TK_PIPE;
            8'h5E:   t = TK_CARET;
            8'h7E:   t = TK_TILDE;
            8'h3E:   t = TK_GT;
            8'h3C:   t = TK_LT;
            8'h21:   t = TK_BANG;
            8'h3D:   t = TK_ASSIGN;
            8'h2E:   t = TK_DOT;
            8'h2C:   t = TK_COMMA;
            8'h3A:   t = TK_COLON;
            8'h3B:   t = TK_SEMI;
            8'h3F:   t = TK_QUEST;
            8'h27:   t = TK_SQUOTE;
            8'h22:   t = TK_DQUOTE;
            8'h7B:   t = TK_LBRACE;
            8'h7D:   t = TK_RBRACE;
            8'h5B:   t = TK_LBRACK;
            8'h5D:   t = TK_RBRACK;
            8'h28:   t = TK_LPAREN;
            8'h29:   t = TK_RPAREN;
            default: t = TK_NONE;
        endcase
        return t;
    endfunction

    // Token reached by appending one byte to a held prefix, TK_NONE if none
    function automatic tok_t extend_code(input tok_t p, input logic [7:0] c);
        tok_t t;
        t = TK_NONE;
        case (p)
            TK_PLUS:
            begin
                if (c == CH_PLUS) t = TK_INC;
                else if (c == CH_EQ) t = TK_ADD_ASN;
            end
            TK_MINUS:
            begin
                if (c == CH_MINUS) t = TK_DEC;
                else if (c == CH_EQ) t = TK_SUB_ASN;
            end
            TK_STAR:    if (c == CH_EQ) t = TK_MUL_ASN;
            TK_SLASH:   if (c == CH_EQ) t = TK_DIV_ASN;
            TK_PERCENT: if (c == CH_EQ) t = TK_MOD_ASN;
            TK_SHL:     if (c == CH_EQ) t = TK_SHL_ASN;
            TK_SHR:     if (c == CH_EQ) t = TK_SHR_ASN;
            TK_AMP:
            begin
                if (c == CH_AMP) t = TK_LAND;
                else if (c == CH_EQ) t = TK_AND_ASN;
            end
            TK_PIPE:
            begin
                if (c == CH_PIPE) t = TK_LOR;
                else if (c == CH_EQ) t = TK_OR_ASN;
            end
            TK_CARET:   if (c == CH_EQ) t = TK_XOR_ASN;
            TK_GT:
            begin
                if (c == CH_GT) t = TK_SHR;
                else if (c == CH_EQ) t = TK_GE;
            end
            TK_LT:
            begin
                if (c == CH_LT) t = TK_SHL;
                else if (c == CH_EQ) t = TK_LE;
            end
            TK_BANG:    if (c == CH_EQ) t = TK_NE;
            TK_ASSIGN:  if (c == CH_EQ) t = TK_EQ;
            default:    t = TK_NONE;
        endcase
        return t;
    endfunction

    function automatic logic [1:0] tok_length(input tok_t t);
        logic [1:0] n;
        case (t)
            TK_NONE:                             n = 2'd0;
            TK_INC, TK_DEC, TK_SHL, TK_SHR,
            TK_GE, TK_LE, TK_LAND, TK_LOR,
            TK_EQ, TK_NE, TK_ADD_ASN, TK_SUB_ASN,
            TK_MUL_ASN, TK_DIV_ASN, TK_MOD_ASN,
            TK_OR_ASN, TK_AND_ASN, TK_XOR_ASN:   n = 2'd2;
            TK_SHL_ASN, TK_SHR_ASN:              n = 2'd3;
            default:                             n = 2'd1;
        endcase
        return n;
    endfunction

endpackage

>>> design/otlm_front.sv
module otlm_front (
    input  logic                src_valid,
    output logic                src_ready,
    input  logic [7:0]          ch,
    input  logic                at_end,
    input  logic                q_full,
    output logic                push,
    output otlm_pkg::item_t     item
);

    otlm_pkg::tok_t single;

    assign single    = otlm_pkg::single_code(ch);
    assign src_ready = !q_full;
    assign push      = src_valid && !q_full;

    always_comb
    begin
        item.ch     = ch;
        item.single = single;
        if (at_end || !otlm_pkg::is_special(ch))
            item.cls = otlm_pkg::CLS_BREAK;
        else if (single == otlm_pkg::TK_NONE)
            item.cls = otlm_pkg::CLS_INVALID;
        else
            item.cls = otlm_pkg::CLS_SPECIAL;
    end

endmodule

>>> design/otlm_queue.sv
module otlm_queue #(
    parameter int DEPTH = otlm_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  otlm_pkg::item_t     item_in,
    output logic                full,
    input  logic                pop,
    output otlm_pkg::item_t     item_out,
    output logic                nonempty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    otlm_pkg::item_t    entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign item_out = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= item_in;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nonempty)
        else $error("queue popped while empty");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue pushed while full");

endmodule

>>> design/otlm_back.sv
module otlm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  otlm_pkg::item_t     q_item,
    output logic                pop,
    output logic                tok_valid,
    input  logic                tok_ready,
    output logic [5:0]          token_code,
    output logic [1:0]          status,
    output logic [1:0]          match_length,
    output logic                char_consumed
);

    otlm_pkg::tok_t     prefix_token_reg, prefix_token_next;
    logic [1:0]         prefix_length_reg, prefix_length_next;
    logic               out_valid_reg, out_valid_next;
    otlm_pkg::tok_t     out_code_reg, out_code_next;
    otlm_pkg::status_t  out_status_reg, out_status_next;
    logic [1:0]         out_length_reg, out_length_next;
    otlm_pkg::tok_t     cand;

    assign pop = q_valid && (!out_valid_reg || tok_ready);

    // With nothing held, a special byte starts a one-character token
    assign cand = (prefix_token_reg == otlm_pkg::TK_NONE) ? q_item.single
                : otlm_pkg::extend_code(prefix_token_reg, q_item.ch);

    always_comb
    begin
        prefix_token_next  = prefix_token_reg;
        prefix_length_next = prefix_length_reg;
        out_valid_next     = out_valid_reg && !tok_ready;
        out_code_next      = out_code_reg;
        out_status_next    = out_status_reg;
        out_length_next    = out_length_reg;
        if (pop)
        begin
            if (q_item.cls == otlm_pkg::CLS_SPECIAL && cand != otlm_pkg::TK_NONE)
            begin
                // grow the prefix, no result yet
                prefix_token_next  = cand;
                prefix_length_next = otlm_pkg::tok_length(cand);
            end
            else
            begin
                out_valid_next     = 1'b1;
                prefix_token_next  = otlm_pkg::TK_NONE;
                prefix_length_next = 2'd0;
                if (q_item.cls == otlm_pkg::CLS_INVALID)
                begin
                    out_code_next   = otlm_pkg::TK_NONE;
                    out_status_next = otlm_pkg::ST_INVALID;
                    out_length_next = 2'd0;
                end
                else if (prefix_token_reg == otlm_pkg::TK_NONE)
                begin
                    out_code_next   = otlm_pkg::TK_NONE;
                    out_status_next = otlm_pkg::ST_NONE;
                    out_length_next = 2'd0;
                end
                else
                begin
                    out_code_next   = prefix_token_reg;
                    out_status_next = otlm_pkg::ST_FOUND;
                    out_length_next = prefix_length_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_token_reg  <= otlm_pkg::TK_NONE;
            prefix_length_reg <= 2'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            prefix_token_reg  <= prefix_token_next;
            prefix_length_reg <= prefix_length_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_code_reg   <= out_code_next;
        out_status_reg <= out_status_next;
        out_length_reg <= out_length_next;
    end

    assign tok_valid     = out_valid_reg;
    assign token_code    = 6'(out_code_reg);
    assign status        = 2'(out_status_reg);
    assign match_length  = out_length_reg;
    assign char_consumed = 1'b0;

    a_found_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == otlm_pkg::ST_FOUND
        |-> out_code_reg != otlm_pkg::TK_NONE && out_length_reg != 2'd0)
        else $error("found status with empty token");

    a_prefix_len: assert property (@(posedge clk) disable iff (!rst_n)
        prefix_length_reg == otlm_pkg::tok_length(prefix_token_reg))
        else $error("prefix length disagrees with prefix token");

    a_invalid_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop && q_item.cls == otlm_pkg::CLS_INVALID
        |=> prefix_token_reg == otlm_pkg::TK_NONE && out_valid_reg
            && out_status_reg == otlm_pkg::ST_INVALID)
        else $error("invalid byte did not clear prefix and report");

endmodule

>>> design/operator_token_longest_match_unit.sv
// Longest-match operator and punctuation recognizer.
// Source channel (src_valid/src_ready, ch, at_end): one byte per item, or an
// end-of-source marker with at_end set. The caller re-presents a byte after a
// result whose char_consumed is 0, since that byte was not absorbed.
// Result channel (tok_valid/tok_ready): token_code, status, match_length,
// char_consumed. An item that starts or extends the held prefix gives no
// result; any other item gives exactly one.
// Throughput: one item per cycle unless a result waits untaken. The front
// classifies the byte in the accept cycle and writes a two-entry queue; the
// back does one table lookup on the held prefix and the byte per cycle and
// loads the output register. A result passes through the queue entry and
// then the output register before tok_valid shows it.
// When the receiver stalls, the result holds in the output register, the
// back stops, and src_ready drops once the queue is full.
// Reset clears the held prefix, the queue and the output valid.
module operator_token_longest_match_unit #(
    parameter int QUEUE_DEPTH = otlm_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_ready,
    input  logic [7:0]  ch,
    input  logic        at_end,
    output logic        tok_valid,
    input  logic        tok_ready,
    output logic [5:0]  token_code,
    output logic [1:0]  status,
    output logic [1:0]  match_length,
    output logic        char_consumed
);

    logic               push, pop, q_full, q_valid;
    otlm_pkg::item_t    front_item, q_item;

    otlm_front u_front (
        .src_valid (src_valid),
        .src_ready (src_ready),
        .ch        (ch),
        .at_end    (at_end),
        .q_full    (q_full),
        .push      (push),
        .item      (front_item)
    );

    otlm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .full     (q_full),
        .pop      (pop),
        .item_out (q_item),
        .nonempty (q_valid)
    );

    otlm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .pop           (pop),
        .tok_valid     (tok_valid),
        .tok_ready     (tok_ready),
        .token_code    (token_code),
        .status        (status),
        .match_length  (match_length),
        .char_consumed (char_consumed)
    );

endmodule
